### rtl/rpn_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// postfix stack evaluator; no dependencies
`timescale 1ns / 1ps

package rpn_pkg;

  // value format and stack geometry
  localparam int DATA_W      = 48;
  localparam int FRAC_BITS   = 16;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 3;

  // iterative unit lengths
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = DATA_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // token codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SAT   = 3'd4;

  // arithmetic unit operations
  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_MFIN,
    ALU_DIV,
    ALU_DFIN
  } alu_op_t;

  // stack update applied when a result is posted
  typedef enum logic [2:0] {
    CM_NONE,
    CM_PUSH,
    CM_OP,
    CM_DIVZ,
    CM_FULL,
    CM_UNDER,
    CM_NOP
  } commit_t;

  typedef struct packed {
    logic    capture;
    logic    rd_issue;
    alu_op_t alu_op;
    commit_t commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sp_full;
    logic sp_lt2;
    logic second_zero;
    logic mul_last;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/rpn_datapath.sv
// stack memory, top-of-stack cache, add/sub, shift-add multiplier,
// restoring divider and output register; uses rpn_pkg
`timescale 1ns / 1ps

module rpn_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rpn_pkg::DATA_W-1:0]   in_number,
  input  rpn_pkg::ctrl_cmd_t           cmd,
  output rpn_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rpn_pkg::DATA_W-1:0]   out_top,
  output logic [rpn_pkg::SP_W-1:0]     out_depth,
  output logic [rpn_pkg::STAT_W-1:0]   out_status
);
  import rpn_pkg::*;

  localparam logic [DATA_W-1:0]   MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]   MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W+1:0]   Q_CAP   = {2'b01, {DATA_W{1'b0}}};

  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    mag_of = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [SP_W-1:0]   sp;
  logic [DATA_W-1:0] top_val;
  logic [DATA_W-1:0] num_r;
  logic [DATA_W-1:0] first;
  logic              neg;
  logic [DATA_W-1:0] mcand;
  logic [DATA_W-1:0] acc_hi;
  logic [DATA_W-1:0] acc_lo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   quo;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] res;
  logic              sat;

  logic [ADDR_W-1:0] below_addr;
  logic [SP_W-1:0]   sp_m2;

  // combinational arithmetic
  logic [DATA_W:0]     sum_add;
  logic [DATA_W:0]     sum_sub;
  logic [DATA_W:0]     mul_sum;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     rem_sub;
  logic                div_ge;
  logic [DATA_W+1:0]   quo_sh;
  logic [2*DATA_W-1:0] prod_sh;
  logic                fin_hi;
  logic [DATA_W-1:0]   fin_mag;
  logic [DATA_W-1:0]   fin_limit;
  logic                fin_sat;
  logic [DATA_W-1:0]   fin_m;
  logic [DATA_W-1:0]   fin_res;
  logic [DATA_W-1:0]   divz_val;
  logic [DATA_W-1:0]   top_shown;

  assign sp_m2      = sp - SP_W'(2);
  assign below_addr = sp_m2[ADDR_W-1:0];

  always_comb begin
    sum_add  = {first[DATA_W-1], first} + {top_val[DATA_W-1], top_val};
    sum_sub  = {first[DATA_W-1], first} - {top_val[DATA_W-1], top_val};
    mul_sum  = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mcand} : {(DATA_W+1){1'b0}});
    rem_sh   = {rem, dvd[DATA_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs};
    div_ge   = rem_sh >= {1'b0, dvs};
    quo_sh   = {quo, div_ge};
    prod_sh  = {acc_hi, acc_lo} >> FRAC_BITS;
    if (cmd.alu_op == ALU_MFIN) begin
      fin_hi  = |prod_sh[2*DATA_W-1:DATA_W];
      fin_mag = prod_sh[DATA_W-1:0];
    end else begin
      fin_hi  = quo[DATA_W];
      fin_mag = quo[DATA_W-1:0];
    end
    fin_limit = neg ? MIN_VAL : MAX_VAL;
    fin_sat   = fin_hi || (fin_mag > fin_limit);
    fin_m     = fin_sat ? fin_limit : fin_mag;
    fin_res   = neg ? (~fin_m + DATA_W'(1)) : fin_m;
    divz_val  = first[DATA_W-1] ? MIN_VAL : MAX_VAL;
    top_shown = (sp != '0) ? top_val : '0;
  end

  // stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit == CM_PUSH) begin
      mem[sp[ADDR_W-1:0]] <= num_r;
    end else if (cmd.commit == CM_OP) begin
      mem[below_addr] <= res;
    end else if (cmd.commit == CM_DIVZ) begin
      mem[below_addr] <= divz_val;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[below_addr];
    end
  end

  // operand and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      num_r <= in_number;
    end
    case (cmd.alu_op)
      ALU_LOAD: begin
        first  <= rd_data;
        neg    <= rd_data[DATA_W-1] ^ top_val[DATA_W-1];
        mcand  <= mag_of(rd_data);
        acc_hi <= '0;
        acc_lo <= mag_of(top_val);
        rem    <= '0;
        dvd    <= mag_of(rd_data);
        dvs    <= mag_of(top_val);
        quo    <= '0;
        cnt    <= '0;
        sat    <= 1'b0;
      end
      ALU_ADD: begin
        sat <= sum_add[DATA_W] != sum_add[DATA_W-1];
        if (sum_add[DATA_W] != sum_add[DATA_W-1]) begin
          res <= sum_add[DATA_W] ? MIN_VAL : MAX_VAL;
        end else begin
          res <= sum_add[DATA_W-1:0];
        end
      end
      ALU_SUB: begin
        sat <= sum_sub[DATA_W] != sum_sub[DATA_W-1];
        if (sum_sub[DATA_W] != sum_sub[DATA_W-1]) begin
          res <= sum_sub[DATA_W] ? MIN_VAL : MAX_VAL;
        end else begin
          res <= sum_sub[DATA_W-1:0];
        end
      end
      ALU_MUL: begin
        acc_hi <= mul_sum[DATA_W:1];
        acc_lo <= {mul_sum[0], acc_lo[DATA_W-1:1]};
        cnt    <= cnt + CNT_W'(1);
      end
      ALU_DIV: begin
        rem <= div_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd <= {dvd[DATA_W-2:0], 1'b0};
        quo <= (quo_sh > Q_CAP) ? Q_CAP[DATA_W:0] : quo_sh[DATA_W:0];
        cnt <= cnt + CNT_W'(1);
      end
      ALU_MFIN, ALU_DFIN: begin
        res <= fin_res;
        sat <= fin_sat;
      end
      default: begin
      end
    endcase
  end

  // stack pointer, top cache and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit != CM_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.commit)
        CM_PUSH:          sp <= sp + SP_W'(1);
        CM_OP, CM_DIVZ:   sp <= sp - SP_W'(1);
        default:          sp <= sp;
      endcase
    end
    case (cmd.commit)
      CM_PUSH: begin
        top_val    <= num_r;
        out_top    <= num_r;
        out_depth  <= sp + SP_W'(1);
        out_status <= ST_OK;
      end
      CM_OP: begin
        top_val    <= res;
        out_top    <= res;
        out_depth  <= sp - SP_W'(1);
        out_status <= sat ? ST_SAT : ST_OK;
      end
      CM_DIVZ: begin
        top_val    <= divz_val;
        out_top    <= divz_val;
        out_depth  <= sp - SP_W'(1);
        out_status <= ST_DIVZ;
      end
      CM_FULL: begin
        out_top    <= top_shown;
        out_depth  <= sp;
        out_status <= ST_FULL;
      end
      CM_UNDER: begin
        out_top    <= top_shown;
        out_depth  <= sp;
        out_status <= ST_UNDER;
      end
      CM_NOP: begin
        out_top    <= top_shown;
        out_depth  <= sp;
        out_status <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign stat.sp_full     = sp == SP_W'(STACK_DEPTH);
  assign stat.sp_lt2      = sp < SP_W'(2);
  assign stat.second_zero = top_val == '0;
  assign stat.mul_last    = cnt == CNT_W'(MUL_STEPS - 1);
  assign stat.div_last    = cnt == CNT_W'(DIV_STEPS - 1);
  assign stat.out_free    = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit == CM_PUSH |-> sp < SP_W'(STACK_DEPTH))
    else $error("push committed on full stack");
  a_op_two: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit == CM_OP || cmd.commit == CM_DIVZ) |-> sp >= SP_W'(2))
    else $error("operator committed with fewer than two entries");
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.commit == CM_PUSH |=> sp == $past(sp) + SP_W'(1))
    else $error("push did not advance stack pointer");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.commit != CM_NONE |-> (!out_valid || out_ready))
    else $error("result posted over an untaken result");
`endif

endmodule

### rtl/rpn_ctrl.sv
// sequencing state machine: token decode, operand fetch, iteration
// control and result posting; uses rpn_pkg
`timescale 1ns / 1ps

module rpn_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpn_pkg::FUNC_W-1:0]  in_func,
  input  rpn_pkg::dp_stat_t           stat,
  output rpn_pkg::ctrl_cmd_t          cmd
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ADD,
    S_SUB,
    S_MUL,
    S_MFIN,
    S_DIV,
    S_DFIN,
    S_COMMIT
  } state_t;

  state_t             state;
  logic [FUNC_W-1:0]  func_r;
  commit_t            kind_r;
  logic               accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.capture  = accept;
    cmd.rd_issue = accept;
    cmd.commit   = CM_NONE;
    case (state)
      S_LOAD:   cmd.alu_op = ALU_LOAD;
      S_ADD:    cmd.alu_op = ALU_ADD;
      S_SUB:    cmd.alu_op = ALU_SUB;
      S_MUL:    cmd.alu_op = ALU_MUL;
      S_MFIN:   cmd.alu_op = ALU_MFIN;
      S_DIV:    cmd.alu_op = ALU_DIV;
      S_DFIN:   cmd.alu_op = ALU_DFIN;
      default:  cmd.alu_op = ALU_IDLE;
    endcase
    if (state == S_COMMIT && stat.out_free) begin
      cmd.commit = kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_r <= CM_NONE;
      func_r <= FUNC_PUSH;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func;
            case (in_func)
              FUNC_PUSH: begin
                kind_r <= stat.sp_full ? CM_FULL : CM_PUSH;
                state  <= S_COMMIT;
              end
              FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                if (stat.sp_lt2) begin
                  kind_r <= CM_UNDER;
                  state  <= S_COMMIT;
                end else begin
                  state <= S_LOAD;
                end
              end
              default: begin
                kind_r <= CM_NOP;
                state  <= S_COMMIT;
              end
            endcase
          end
        end
        S_LOAD: begin
          case (func_r)
            FUNC_ADD: begin
              kind_r <= CM_OP;
              state  <= S_ADD;
            end
            FUNC_SUB: begin
              kind_r <= CM_OP;
              state  <= S_SUB;
            end
            FUNC_MUL: begin
              kind_r <= CM_OP;
              state  <= S_MUL;
            end
            FUNC_DIV: begin
              if (stat.second_zero) begin
                kind_r <= CM_DIVZ;
                state  <= S_COMMIT;
              end else begin
                kind_r <= CM_OP;
                state  <= S_DIV;
              end
            end
            default: begin
              kind_r <= CM_NOP;
              state  <= S_COMMIT;
            end
          endcase
        end
        S_ADD, S_SUB, S_MFIN, S_DFIN: begin
          state <= S_COMMIT;
        end
        S_MUL: begin
          if (stat.mul_last) begin
            state <= S_MFIN;
          end
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_DFIN;
          end
        end
        S_COMMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rpn_stack_evaluator_top.sv
// top level of the postfix (rpn) stack evaluator on signed q31.16 values;
// joins rpn_ctrl and rpn_datapath, uses rpn_pkg
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_axis    in   s_tvalid / s_tready  s_tdata: func, number_value
// m_axis    out  m_tvalid / m_tready  m_tdata: top_value, stack_depth, status
//
// token flow, accept to next accept: push or rejected token posts at once;
// add/sub loads, computes, posts; multiply loads, runs 48 shift-add steps,
// finishes, posts; divide the same with 64 restoring steps; divide by zero
// loads, then posts. the result register loads as s_tready returns.
// one token is in work at a time; the next is accepted once the previous
// result is posted to the output register, even if not yet taken.
// synchronous active-high reset empties the stack and drops any result.
// a stalled output holds the block in its posting state until taken.

module rpn_stack_evaluator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [2:0] func, [50:3] number_value, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [47:0] top_value, [54:48] stack_depth,
                                 // [57:55] status, rest zero
);
  import rpn_pkg::*;

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic [DATA_W-1:0]  top_value;
  logic [SP_W-1:0]    stack_depth;
  logic [STAT_W-1:0]  status;

  // token decode and sequencing
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tdata[FUNC_W-1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, arithmetic and output register
  rpn_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_number  (s_tdata[FUNC_W +: DATA_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_top    (top_value),
    .out_depth  (stack_depth),
    .out_status (status)
  );

  // pack result fields, lowest first
  assign m_tdata = {6'd0, status, stack_depth, top_value};

endmodule
